// ===== hw/rtl/olrs_pkg.sv =====
// ----------------------------------------------------------------------------
// olrs_pkg
// Shared constants, types and saturation helper for the online LMS
// regression core.
// ----------------------------------------------------------------------------
package olrs_pkg;

   localparam int MAX_FEATURES = 8;
   localparam int LANE_IDX_W   = $clog2(MAX_FEATURES);
   localparam int LANE_CNT_W   = 4;
   localparam int ACC_W        = 52;
   localparam int MUL_A_W      = 33;
   localparam int MUL_B_W      = 17;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;
   localparam int STEP_W       = 48;

   localparam logic [LANE_CNT_W-1:0] LANE_MAX = LANE_CNT_W'(MAX_FEATURES);

   // register indexes
   localparam logic CSR_LEARNING_RATE = 1'b0;
   localparam logic CSR_FEATURE_COUNT = 1'b1;

   localparam logic [15:0] LR_RESET = 16'd655;
   localparam logic [3:0]  FC_RESET = 4'd8;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   // per-cycle datapath commands
   typedef struct packed {
      logic load;
      logic mac_mul;
      logic mac_add;
      logic pred;
      logic err;
      logic step_mul;
      logic bias_upd;
      logic upd_lo;
      logic upd_hi;
      logic upd_sum;
      logic upd_add;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic lanes_zero;
      logic last_lane;
      logic train;
      logic out_free;
   } dp_status_type;

   // {clipped flag, 32-bit value}
   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < SAT_LO) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/online_linear_regression_sgd_core.sv =====
// ----------------------------------------------------------------------------
// online_linear_regression_sgd_core
// LMS linear regression: predicts bias + w.x per item and, on a train item,
// updates each weight by learning_rate * error * feature and the bias by learning_rate * error.
// ----------------------------------------------------------------------------
// L = lanes in use (feature_count clamped to 8). A predict item runs the
// dot product over L lanes, then prediction and error; a train item then
// also updates the bias and the L weights.
// One item in flight at a time; the next is taken the cycle after the result
// has moved to the output register. A stalled full output register holds the
// finished item back. All multiplies go through the single shared 33x17
// multiplier. Reset (synchronous, high) clears weights and bias and
// restores learning_rate = 655, feature_count = 8.
module online_linear_regression_sgd_core
   import olrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // config writes, always ready
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   // sample items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [15:0] req_feature_0,
   input  logic signed [15:0] req_feature_1,
   input  logic signed [15:0] req_feature_2,
   input  logic signed [15:0] req_feature_3,
   input  logic signed [15:0] req_feature_4,
   input  logic signed [15:0] req_feature_5,
   input  logic signed [15:0] req_feature_6,
   input  logic signed [15:0] req_feature_7,
   input  logic signed [15:0] req_target,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_prediction,
   output logic signed [31:0] rsp_error,
   output logic               rsp_saturated
);

   ctl_cmd_type        cmd;
   dp_status_type      status;
   logic signed [15:0] feature [MAX_FEATURES];

   // config must only be written while idle (the block does not enforce it), so no backpressure needed
   assign csr_ready = 1'b1;

   assign feature[0] = req_feature_0;
   assign feature[1] = req_feature_1;
   assign feature[2] = req_feature_2;
   assign feature[3] = req_feature_3;
   assign feature[4] = req_feature_4;
   assign feature[5] = req_feature_5;
   assign feature[6] = req_feature_6;
   assign feature[7] = req_feature_7;

   olrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   olrs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_cmd        (req_cmd),
      .req_feature    (feature),
      .req_target     (req_target),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prediction (rsp_prediction),
      .rsp_error      (rsp_error),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// ===== hw/rtl/olrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// olrs_ctrl
// Sequencer: steps the datapath through the dot product, error and, on a train
// item, the bias and per-lane weight updates, then hands the result to the output register.
// ----------------------------------------------------------------------------
module olrs_ctrl
   import olrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_MAC_MUL  = 12'b0000_0000_0010,
      ST_MAC_ADD  = 12'b0000_0000_0100,
      ST_PRED     = 12'b0000_0000_1000,
      ST_ERR      = 12'b0000_0001_0000,
      ST_STEP_MUL = 12'b0000_0010_0000,
      ST_BIAS_UPD = 12'b0000_0100_0000,
      ST_UPD_LO   = 12'b0000_1000_0000,
      ST_UPD_HI   = 12'b0001_0000_0000,
      ST_UPD_SUM  = 12'b0010_0000_0000,
      ST_UPD_ADD  = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.lanes_zero ? ST_PRED : ST_MAC_MUL;
            end
         end
         ST_MAC_MUL: begin
            cmd.mac_mul = 1'b1;
            state_in    = ST_MAC_ADD;
         end
         ST_MAC_ADD: begin
            cmd.mac_add = 1'b1;
            state_in    = status.last_lane ? ST_PRED : ST_MAC_MUL;
         end
         ST_PRED: begin
            cmd.pred = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = status.train ? ST_STEP_MUL : ST_FINISH;
         end
         ST_STEP_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = ST_BIAS_UPD;
         end
         ST_BIAS_UPD: begin
            cmd.bias_upd = 1'b1;
            state_in     = status.lanes_zero ? ST_FINISH : ST_UPD_LO;
         end
         ST_UPD_LO: begin
            cmd.upd_lo = 1'b1;
            state_in   = ST_UPD_HI;
         end
         ST_UPD_HI: begin
            cmd.upd_hi = 1'b1;
            state_in   = ST_UPD_SUM;
         end
         ST_UPD_SUM: begin
            cmd.upd_sum = 1'b1;
            state_in    = ST_UPD_ADD;
         end
         ST_UPD_ADD: begin
            cmd.upd_add = 1'b1;
            state_in    = status.last_lane ? ST_FINISH : ST_UPD_LO;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/olrs_datapath.sv =====
// ----------------------------------------------------------------------------
// olrs_datapath
// Weight and bias storage, config registers, one shared 33x17 multiplier,
// accumulator, saturating adders and the output register.
// ----------------------------------------------------------------------------
module olrs_datapath
   import olrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_status_type       status,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [15:0]         csr_data,
   input  logic                req_cmd,
   input  logic signed [15:0]  req_feature [MAX_FEATURES],
   input  logic signed [15:0]  req_target,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_prediction,
   output logic signed [31:0]  rsp_error,
   output logic                rsp_saturated
);

   logic [15:0]             lr_ff, lr_in;
   logic [3:0]              fc_ff, fc_in;
   logic signed [31:0]      weight_ff [MAX_FEATURES];
   logic signed [31:0]      weight_in [MAX_FEATURES];
   logic signed [31:0]      bias_ff, bias_in;
   logic signed [15:0]      feat_ff [MAX_FEATURES];
   logic signed [15:0]      tgt_ff;
   logic                    train_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [STEP_W-1:0] step_ff;
   logic signed [32:0]      lo_ff;
   logic signed [63:0]      sum_ff;
   logic signed [31:0]      pred_ff, pred_in;
   logic signed [31:0]      err_ff, err_in;
   logic                    sat_ff, sat_in;
   logic [LANE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      rsp_pred_ff, rsp_err_ff;
   logic                    rsp_sat_ff;

   logic [LANE_CNT_W-1:0]   lanes;
   logic [LANE_IDX_W-1:0]   idx;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic [32:0]             clip;

   assign lanes = (fc_ff > LANE_MAX) ? LANE_MAX : fc_ff;
   assign idx   = cnt_ff[LANE_IDX_W-1:0];

   assign status.lanes_zero = (lanes == '0);
   assign status.last_lane  = ((cnt_ff + LANE_CNT_W'(1)) == lanes);
   assign status.train      = train_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.mac_mul) begin
         mul_a = MUL_A_W'(weight_ff[idx]);
         mul_b = MUL_B_W'(feat_ff[idx]);
      end else if (cmd.step_mul) begin
         mul_a = MUL_A_W'(err_ff);
         mul_b = $signed({1'b0, lr_ff});
      end else if (cmd.upd_lo) begin
         mul_a = $signed({17'b0, step_ff[15:0]});
         mul_b = MUL_B_W'(feat_ff[idx]);
      end else if (cmd.upd_hi) begin
         mul_a = MUL_A_W'($signed(step_ff[STEP_W-1:16]));
         mul_b = MUL_B_W'(feat_ff[idx]);
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      lr_in        = lr_ff;
      fc_in        = fc_ff;
      weight_in    = weight_ff;
      bias_in      = bias_ff;
      acc_in       = acc_ff;
      pred_in      = pred_ff;
      err_in       = err_ff;
      sat_in       = sat_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      clip         = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_LEARNING_RATE: lr_in = csr_data;
            CSR_FEATURE_COUNT: fc_in = csr_data[3:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         acc_in = ACC_W'($signed({bias_ff, 8'h00}));
         sat_in = 1'b0;
         cnt_in = '0;
      end

      if (cmd.mac_add) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
         cnt_in = cnt_ff + LANE_CNT_W'(1);
      end

      if (cmd.pred) begin
         clip    = sat32(64'(acc_ff >>> 8));
         pred_in = clip[31:0];
         sat_in  = sat_ff | clip[32];
      end

      if (cmd.err) begin
         if (train_ff) begin
            clip   = sat32(64'($signed({tgt_ff, 8'h00})) - 64'(pred_ff));
            err_in = clip[31:0];
            sat_in = sat_ff | clip[32];
         end else begin
            err_in = '0;
         end
      end

      // bias step uses the lr*err product still in the product register
      if (cmd.bias_upd) begin
         clip    = sat32(64'(bias_ff) + 64'(prod_ff >>> 16));
         bias_in = clip[31:0];
         sat_in  = sat_ff | clip[32];
         cnt_in  = '0;
      end

      if (cmd.upd_add) begin
         clip           = sat32(64'(weight_ff[idx]) + (sum_ff >>> 24));
         weight_in[idx] = clip[31:0];
         sat_in         = sat_ff | clip[32];
         cnt_in         = cnt_ff + LANE_CNT_W'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff        <= LR_RESET;
         fc_ff        <= FC_RESET;
         weight_ff    <= '{default: '0};
         bias_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lr_ff        <= lr_in;
         fc_ff        <= fc_in;
         weight_ff    <= weight_in;
         bias_ff      <= bias_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      pred_ff <= pred_in;
      err_ff  <= err_in;
      sat_ff  <= sat_in;
      cnt_ff  <= cnt_in;
      prod_ff <= mul_p;
      if (cmd.load) begin
         feat_ff  <= req_feature;
         tgt_ff   <= req_target;
         train_ff <= req_cmd;
      end
      if (cmd.bias_upd) begin
         step_ff <= prod_ff[STEP_W-1:0];
      end
      if (cmd.upd_hi) begin
         lo_ff <= prod_ff[32:0];
      end
      if (cmd.upd_sum) begin
         sum_ff <= (64'(prod_ff) <<< 16) + 64'(lo_ff);
      end
      if (cmd.out_load) begin
         rsp_pred_ff <= pred_ff;
         rsp_err_ff  <= err_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_error      = rsp_err_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
